FILE: rtl/mm3_pkg.sv
package mm3_pkg;

   localparam logic [31:0] C1         = 32'hcc9e2d51;
   localparam logic [31:0] C2         = 32'h1b873593;
   localparam logic [31:0] MIX_ADD    = 32'he6546b64;
   localparam logic [31:0] F1         = 32'h85ebca6b;
   localparam logic [31:0] F2         = 32'hc2b2ae35;
   localparam logic [31:0] SEED_RESET = 32'd42;

   // byte counts carried with a scrambled word
   localparam logic [2:0] NB_NONE = 3'd0;
   localparam logic [2:0] NB_ONE  = 3'd1;
   localparam logic [2:0] NB_TWO  = 3'd2;
   localparam logic [2:0] NB_THREE = 3'd3;
   localparam logic [2:0] NB_FULL = 3'd4;

   typedef struct packed {
      logic [31:0] k;
      logic [2:0]  nbytes;
      logic        last;
   } work_type;

   typedef struct packed {
      logic [31:0] hash_value;
      logic [31:0] message_length;
   } rsp_type;

endpackage

FILE: rtl/mm3_fifo.sv
module mm3_fifo #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             wdata,
   input  logic                         pop,
   output logic [WIDTH-1:0]             rdata,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_pop;

   assign empty  = (cnt_ff == '0);
   assign count  = cnt_ff;
   assign rdata  = mem_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: rtl/mm3_front.sv
module mm3_front #(
   parameter int DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [31:0]                 data_word,
   input  logic [2:0]                  valid_bytes,
   input  logic                        last,
   input  logic [$clog2(DEPTH+1)-1:0]  queue_count,
   output logic                        full,
   output logic                        work_push,
   output mm3_pkg::work_type           work
);

   localparam int CNT_W = $clog2(DEPTH+1);

   logic        accept;
   logic [2:0]  nb;
   logic [31:0] masked;
   logic [CNT_W:0] used;

   logic        v1_ff, v1_in;
   logic [31:0] m1_ff, m1_in;
   logic [2:0]  nb1_ff;
   logic        last1_ff;

   logic        v2_ff, v2_in;
   logic [31:0] k2_ff, k2_in;
   logic [31:0] rot1;
   logic [2:0]  nb2_ff;
   logic        last2_ff;

   // words in the scramble stages hold a queue slot already
   assign used   = {1'b0, queue_count} + (CNT_W+1)'(v1_ff) + (CNT_W+1)'(v2_ff);
   assign full   = (used >= (CNT_W+1)'(DEPTH));
   assign accept = push && !full;

   always_comb begin
      // non-last words always count as a full word
      if (!last || (valid_bytes > mm3_pkg::NB_FULL)) begin
         nb = mm3_pkg::NB_FULL;
      end else begin
         nb = valid_bytes;
      end
      case (nb)
         mm3_pkg::NB_NONE:  masked = 32'h0;
         mm3_pkg::NB_ONE:   masked = {24'h0, data_word[7:0]};
         mm3_pkg::NB_TWO:   masked = {16'h0, data_word[15:0]};
         mm3_pkg::NB_THREE: masked = {8'h0, data_word[23:0]};
         default:           masked = data_word;
      endcase
   end

   assign v1_in = accept;
   assign m1_in = masked * mm3_pkg::C1;
   assign rot1  = {m1_ff[16:0], m1_ff[31:17]};
   assign v2_in = v1_ff;
   assign k2_in = rot1 * mm3_pkg::C2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      m1_ff    <= m1_in;
      nb1_ff   <= nb;
      last1_ff <= last;
      k2_ff    <= k2_in;
      nb2_ff   <= nb1_ff;
      last2_ff <= last1_ff;
   end

   assign work_push   = v2_ff;
   assign work.k      = k2_ff;
   assign work.nbytes = nb2_ff;
   assign work.last   = last2_ff;

endmodule

FILE: rtl/mm3_back.sv
module mm3_back #(
   parameter int DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [31:0]                 seed,
   input  logic                        work_empty,
   input  mm3_pkg::work_type           work,
   output logic                        work_pop,
   input  logic [$clog2(DEPTH+1)-1:0]  rsp_count,
   output logic                        rsp_push,
   output mm3_pkg::rsp_type            rsp
);

   localparam int CNT_W = $clog2(DEPTH+1);

   logic        in_msg_ff, in_msg_in;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] total_ff, total_in;

   logic [31:0] h_base, len_base, h_x, h_rot, h_new, len_new;
   logic [CNT_W+1:0] used;
   logic        rsp_room;

   logic        f1_ff, f1_in;
   logic [31:0] v0_ff, v0_in;
   logic [31:0] len1_ff;
   logic        f2_ff;
   logic [31:0] p1_ff, p1_in, x1;
   logic [31:0] len2_ff;
   logic        f3_ff;
   logic [31:0] p2_ff, p2_in, x2;
   logic [31:0] len3_ff;

   // finalizer stages hold a result slot already
   assign used = (CNT_W+2)'(rsp_count) + (CNT_W+2)'(f1_ff) + (CNT_W+2)'(f2_ff)
               + (CNT_W+2)'(f3_ff);
   assign rsp_room = (used < (CNT_W+2)'(DEPTH));
   assign work_pop = !work_empty && (!work.last || rsp_room);

   always_comb begin
      h_base   = in_msg_ff ? hash_ff : seed;
      len_base = in_msg_ff ? total_ff : 32'h0;
      h_x      = h_base ^ work.k;
      h_rot    = {h_x[18:0], h_x[31:19]};
      case (work.nbytes)
         mm3_pkg::NB_FULL: h_new = h_rot + {h_rot[29:0], 2'b00} + mm3_pkg::MIX_ADD;
         mm3_pkg::NB_NONE: h_new = h_base;
         default:          h_new = h_x;
      endcase
      len_new = len_base + {29'h0, work.nbytes};

      in_msg_in = in_msg_ff;
      hash_in   = hash_ff;
      total_in  = total_ff;
      f1_in     = 1'b0;
      v0_in     = h_new ^ len_new;
      if (work_pop) begin
         if (work.last) begin
            in_msg_in = 1'b0;
            f1_in     = 1'b1;
         end else begin
            in_msg_in = 1'b1;
            hash_in   = h_new;
            total_in  = len_new;
         end
      end
   end

   assign x1    = v0_ff ^ {16'h0, v0_ff[31:16]};
   assign p1_in = x1 * mm3_pkg::F1;
   assign x2    = p1_ff ^ {13'h0, p1_ff[31:13]};
   assign p2_in = x2 * mm3_pkg::F2;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
         f1_ff     <= 1'b0;
         f2_ff     <= 1'b0;
         f3_ff     <= 1'b0;
      end else begin
         in_msg_ff <= in_msg_in;
         f1_ff     <= f1_in;
         f2_ff     <= f1_ff;
         f3_ff     <= f2_ff;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff  <= hash_in;
      total_ff <= total_in;
      v0_ff    <= v0_in;
      len1_ff  <= len_new;
      p1_ff    <= p1_in;
      len2_ff  <= len1_ff;
      p2_ff    <= p2_in;
      len3_ff  <= len2_ff;
   end

   assign rsp_push           = f3_ff;
   assign rsp.hash_value     = p2_ff ^ {16'h0, p2_ff[31:16]};
   assign rsp.message_length = len3_ff;

endmodule

FILE: rtl/murmur3_32_hash_stream_unit.sv
// Channel  | Direction | Handshake              | Payload
// req_     | in        | req_push / req_full    | data_word, valid_bytes, last
// rsp_     | out       | rsp_empty / rsp_pop    | hash_value, message_length
// csr_     | in        | csr_valid / csr_ready  | seed
//
// Sustained rate is one word per cycle while req_full is low and no last word
// waits for result room; scramble stages, work queue and update loop each
// move one word a cycle. Results leave via the finalizer and result queue.
// Reset empties both queues and the pipeline and loads seed 42.
// req_full rises once the work queue and scramble stages hold WORK_DEPTH words;
// a last word waits in the queue while the result queue and finalizer hold
// RSP_DEPTH results.
module murmur3_32_hash_stream_unit #(
   parameter int WORK_DEPTH = 4,
   parameter int RSP_DEPTH  = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_last,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_hash_value,
   output logic [31:0] rsp_message_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_seed
);

   localparam int WCNT_W = $clog2(WORK_DEPTH+1);
   localparam int RCNT_W = $clog2(RSP_DEPTH+1);
   localparam int WORK_W = $bits(mm3_pkg::work_type);
   localparam int RSP_W  = $bits(mm3_pkg::rsp_type);

   logic [31:0] seed_ff, seed_in;

   logic              work_push, work_pop, work_empty;
   mm3_pkg::work_type work_wr, work_rd;
   logic [WCNT_W-1:0] work_count;

   logic              rsp_push;
   mm3_pkg::rsp_type  rsp_wr, rsp_rd;
   logic [RCNT_W-1:0] rsp_count;

   assign csr_ready = 1'b1;
   assign seed_in   = (csr_valid && csr_ready) ? csr_seed : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= mm3_pkg::SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   mm3_front #(.DEPTH(WORK_DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .data_word   (req_data_word),
      .valid_bytes (req_valid_bytes),
      .last        (req_last),
      .queue_count (work_count),
      .full        (req_full),
      .work_push   (work_push),
      .work        (work_wr)
   );

   mm3_fifo #(.DEPTH(WORK_DEPTH), .WIDTH(WORK_W)) u_work_q (
      .clock (clock),
      .reset (reset),
      .push  (work_push),
      .wdata (work_wr),
      .pop   (work_pop),
      .rdata (work_rd),
      .empty (work_empty),
      .count (work_count)
   );

   mm3_back #(.DEPTH(RSP_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .seed       (seed_ff),
      .work_empty (work_empty),
      .work       (work_rd),
      .work_pop   (work_pop),
      .rsp_count  (rsp_count),
      .rsp_push   (rsp_push),
      .rsp        (rsp_wr)
   );

   mm3_fifo #(.DEPTH(RSP_DEPTH), .WIDTH(RSP_W)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wr),
      .pop   (rsp_pop),
      .rdata (rsp_rd),
      .empty (rsp_empty),
      .count (rsp_count)
   );

   assign rsp_hash_value     = rsp_rd.hash_value;
   assign rsp_message_length = rsp_rd.message_length;

endmodule

FILE: rtl/mm3_checker.sv
module mm3_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [31:0] rsp_hash_value,
   input logic [31:0] rsp_message_length,
   input logic        csr_ready
);

   // reset leaves no result behind
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // reset frees every word slot
   a_reset_room: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input still full after reset");

   // a waiting result holds until it is popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_hash_value) && $stable(rsp_message_length)))
      else $error("waiting result changed before pop");

   // the seed register takes a write in any cycle
   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr_ready dropped");

endmodule

bind murmur3_32_hash_stream_unit mm3_checker u_mm3_checker (
   .clock              (clock),
   .reset              (reset),
   .req_full           (req_full),
   .rsp_empty          (rsp_empty),
   .rsp_pop            (rsp_pop),
   .rsp_hash_value     (rsp_hash_value),
   .rsp_message_length (rsp_message_length),
   .csr_ready          (csr_ready)
);
